>>> design/bpa_pkg.sv
package bpa_pkg;

    localparam int MAP_WORDS_DEF = 1024;
    localparam int WORD_BITS     = 64;
    localparam int CNT_W         = 17;
    localparam int PAGE_W        = 16;
    localparam int RANGE_W       = 17;
    localparam int CFG_W         = 11;
    localparam logic [CNT_W-1:0] COUNT_MAX = 17'd65536;
    localparam logic [CFG_W-1:0] WORDS_RESET = 11'd1024;

    typedef enum logic [1:0] {
        FUNC_MARK_FREE = 2'd0,
        FUNC_RESERVE   = 2'd1,
        FUNC_ALLOC     = 2'd2,
        FUNC_FREE      = 2'd3
    } func_t;

    typedef struct packed {
        logic [1:0]         func;
        logic [15:0]        range_begin;
        logic [RANGE_W-1:0] range_end;
    } cmd_t;

    typedef struct packed {
        logic               status;
        logic [PAGE_W-1:0]  page;
        logic [CNT_W-1:0]   free_pages;
        logic [CNT_W-1:0]   used_pages;
    } rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_DECODE,
        ST_MRD,
        ST_MWAIT,
        ST_MWR,
        ST_ARD,
        ST_AWAIT,
        ST_ACHK,
        ST_FRD,
        ST_FWAIT,
        ST_FWR,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic clr_step;
        logic mem_rd;
        logic mem_wr_mark;
        logic mem_wr_alloc;
        logic mem_wr_free;
        logic mark_next;
        logic scan_next;
        logic finish_mark;
        logic finish_reserve;
        logic finish_alloc_ok;
        logic finish_alloc_fail;
        logic finish_free;
    } ctl_t;

    typedef struct packed {
        logic clr_last;
        logic func_mark;
        logic func_reserve;
        logic func_alloc;
        logic mark_empty;
        logic mark_last;
        logic mark_skip;
        logic scan_none;
        logic word_hit;
        logic scan_last;
        logic free_in_map;
    } sts_t;

endpackage

>>> design/bpa_ram.sv
module bpa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> design/bpa_ctrl.sv
module bpa_ctrl
    import bpa_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   start,
    input  sts_t   sts,
    output logic   busy,
    output ctl_t   ctl
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:  if (sts.clr_last) state_next = ST_IDLE;
            ST_IDLE:   if (start) state_next = ST_DECODE;
            ST_DECODE:
            begin
                if (sts.func_mark)
                begin
                    state_next = sts.mark_empty ? ST_DONE : ST_MRD;
                end
                else if (sts.func_reserve)
                begin
                    state_next = ST_DONE;
                end
                else if (sts.func_alloc)
                begin
                    state_next = sts.scan_none ? ST_DONE : ST_ARD;
                end
                else
                begin
                    state_next = sts.free_in_map ? ST_FRD : ST_DONE;
                end
            end
            ST_MRD:
            begin
                if (sts.mark_skip)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_MWAIT;
                end
            end
            ST_MWAIT:  state_next = ST_MWR;
            ST_MWR:    state_next = sts.mark_last ? ST_DONE : ST_MRD;
            ST_ARD:    state_next = ST_AWAIT;
            ST_AWAIT:  state_next = ST_ACHK;
            ST_ACHK:
            begin
                if (sts.word_hit || sts.scan_last)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_ARD;
                end
            end
            ST_FRD:    state_next = ST_FWAIT;
            ST_FWAIT:  state_next = ST_FWR;
            ST_FWR:    state_next = ST_DONE;
            ST_DONE:   state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctl  = '0;
        busy = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                busy     = 1'b0;
                ctl.load = start;
            end
            ST_CLEAR:  ctl.clr_step = 1'b1;
            ST_DECODE:
            begin
                if (sts.func_mark && sts.mark_empty)
                begin
                    ctl.finish_mark = 1'b1;
                end
                if (sts.func_reserve)
                begin
                    ctl.finish_reserve = 1'b1;
                end
                if (sts.func_alloc && sts.scan_none)
                begin
                    ctl.finish_alloc_fail = 1'b1;
                end
                if (!sts.func_mark && !sts.func_reserve && !sts.func_alloc
                    && !sts.free_in_map)
                begin
                    ctl.finish_free = 1'b1;
                end
            end
            ST_MRD:
            begin
                ctl.mem_rd = 1'b1;
                ctl.finish_mark = sts.mark_skip;
            end
            ST_MWR:
            begin
                ctl.mem_wr_mark = 1'b1;
                ctl.mark_next   = 1'b1;
                ctl.finish_mark = sts.mark_last;
            end
            ST_ARD:    ctl.mem_rd = 1'b1;
            ST_ACHK:
            begin
                ctl.mem_wr_alloc      = sts.word_hit;
                ctl.finish_alloc_ok   = sts.word_hit;
                ctl.finish_alloc_fail = !sts.word_hit && sts.scan_last;
                ctl.scan_next         = !sts.word_hit;
            end
            ST_FRD:    ctl.mem_rd = 1'b1;
            ST_FWR:
            begin
                ctl.mem_wr_free = 1'b1;
                ctl.finish_free = 1'b1;
            end
            default:   ctl = '0;
        endcase
    end

endmodule

>>> design/bpa_dp.sv
module bpa_dp
    import bpa_pkg::*;
#(
    parameter int MAP_WORDS = MAP_WORDS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  ctl_t               ctl,
    input  cmd_t               cmd,
    input  logic               cfg_we,
    input  logic [CFG_W-1:0]   cfg_wdata,
    output sts_t               sts,
    output logic               done,
    output rsp_t               rsp
);

    localparam int AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int WW = 17;
    localparam logic [WW-1:0] MAP_WORDS_W = WW'(MAP_WORDS);

    logic [CFG_W-1:0]    words_reg;
    logic [1:0]          func_reg;
    logic [15:0]         rb_reg;
    logic [RANGE_W-1:0]  re_reg;
    logic [WW-1:0]       ptr_reg;
    logic [WW-1:0]       ptr_next;
    logic [WW-1:0]       limit_reg;
    logic [CNT_W-1:0]    avail_reg;
    logic [CNT_W-1:0]    used_reg;
    logic                done_reg;
    rsp_t                rsp_reg;

    logic                we;
    logic [AW-1:0]       waddr;
    logic [AW-1:0]       raddr;
    logic [63:0]         wdata;
    logic [63:0]         rdata;

    logic [RANGE_W-1:0]  len;
    logic [WW-1:0]       end_word;
    logic [WW-1:0]       first_word;
    logic [63:0]         range_mask;
    logic [5:0]          lo_bit;
    logic [6:0]          hi_bit;
    logic [5:0]          hit_bit;
    logic                hit_any;
    logic [CNT_W-1:0]    avail_plus_len;
    logic [CNT_W:0]      sum_wide;
    logic [CNT_W-1:0]    used_plus_len;
    logic [CNT_W:0]      sum2_wide;
    logic [CNT_W-1:0]    avail_inc;
    logic [CNT_W-1:0]    avail_dec;
    logic [CNT_W-1:0]    used_inc;
    logic [CNT_W-1:0]    used_dec;
    logic [WW-1:0]       cfg_ext;

    assign len        = (re_reg > RANGE_W'(rb_reg)) ? re_reg - RANGE_W'(rb_reg) : '0;
    assign first_word = WW'(rb_reg[15:6]);
    assign end_word   = WW'((re_reg - 17'd1) >> 6);
    assign cfg_ext    = WW'(words_reg);

    always_comb
    begin
        lo_bit = (ptr_reg == first_word) ? rb_reg[5:0] : 6'd0;
        hi_bit = (ptr_reg == end_word) ? 7'(re_reg[5:0] == 6'd0 ? 7'd64 : {1'b0, re_reg[5:0]})
                                       : 7'd64;
        for (int i = 0; i < 64; i++)
        begin
            range_mask[i] = (7'(i) < hi_bit) && (6'(i) >= lo_bit);
        end
    end

    always_comb
    begin
        hit_any = |rdata;
        hit_bit = '0;
        for (int i = 63; i >= 0; i--)
        begin
            if (rdata[i])
            begin
                hit_bit = 6'(i);
            end
        end
    end

    assign sum_wide       = {1'b0, avail_reg} + {1'b0, len};
    assign avail_plus_len = (sum_wide > {1'b0, COUNT_MAX}) ? COUNT_MAX : sum_wide[CNT_W-1:0];
    assign sum2_wide      = {1'b0, used_reg} + {1'b0, len};
    assign used_plus_len  = (sum2_wide > {1'b0, COUNT_MAX}) ? COUNT_MAX : sum2_wide[CNT_W-1:0];
    assign avail_inc      = (avail_reg == COUNT_MAX) ? COUNT_MAX : avail_reg + 17'd1;
    assign used_inc       = (used_reg == COUNT_MAX) ? COUNT_MAX : used_reg + 17'd1;
    assign avail_dec      = (avail_reg == '0) ? '0 : avail_reg - 17'd1;
    assign used_dec       = (used_reg == '0) ? '0 : used_reg - 17'd1;

    always_comb
    begin
        we    = ctl.clr_step | ctl.mem_wr_mark | ctl.mem_wr_alloc | ctl.mem_wr_free;
        waddr = ptr_reg[AW-1:0];
        raddr = ptr_reg[AW-1:0];
        wdata = '0;
        if (ctl.mem_wr_mark)
        begin
            wdata = rdata | range_mask;
        end
        else if (ctl.mem_wr_alloc)
        begin
            wdata = rdata & ~(64'd1 << hit_bit);
        end
        else if (ctl.mem_wr_free)
        begin
            wdata = rdata | (64'd1 << rb_reg[5:0]);
        end
    end

    bpa_ram #(.WIDTH(64), .DEPTH(MAP_WORDS)) u_map (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb
    begin
        ptr_next = ptr_reg;
        if (ctl.clr_step || ctl.mark_next || ctl.scan_next)
        begin
            ptr_next = ptr_reg + 17'd1;
        end
        else if (ctl.load)
        begin
            ptr_next = '0;
        end
        else if (sts.func_mark && !ctl.mem_rd && !ctl.mem_wr_mark && func_reg == FUNC_MARK_FREE
                 && ptr_reg == '1)
        begin
            ptr_next = first_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            words_reg <= WORDS_RESET;
            ptr_reg   <= '0;
            avail_reg <= '0;
            used_reg  <= '0;
            done_reg  <= 1'b0;
            limit_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cfg_we)
            begin
                words_reg <= cfg_wdata;
            end
            ptr_reg <= ptr_next;
            if (ctl.load)
            begin
                limit_reg <= (cfg_ext > MAP_WORDS_W) ? MAP_WORDS_W : cfg_ext;
                ptr_reg   <= (cmd.func == FUNC_MARK_FREE || cmd.func == FUNC_FREE)
                             ? WW'(cmd.range_begin[15:6]) : '0;
            end
            if (ctl.finish_mark)
            begin
                avail_reg <= avail_plus_len;
            end
            if (ctl.finish_reserve)
            begin
                used_reg <= used_plus_len;
            end
            if (ctl.finish_alloc_ok)
            begin
                avail_reg <= avail_dec;
                used_reg  <= used_inc;
            end
            if (ctl.finish_free)
            begin
                avail_reg <= avail_inc;
                used_reg  <= used_dec;
            end
            if (ctl.finish_mark || ctl.finish_reserve || ctl.finish_alloc_ok
                || ctl.finish_alloc_fail || ctl.finish_free)
            begin
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            func_reg <= cmd.func;
            rb_reg   <= cmd.range_begin;
            re_reg   <= cmd.range_end;
        end
        if (ctl.finish_mark || ctl.finish_reserve || ctl.finish_alloc_ok
            || ctl.finish_alloc_fail || ctl.finish_free)
        begin
            rsp_reg.status <= ctl.finish_alloc_fail;
            rsp_reg.page   <= ctl.finish_alloc_ok ? {ptr_reg[9:0], hit_bit} : '0;
            rsp_reg.free_pages <= ctl.finish_mark ? avail_plus_len
                                : ctl.finish_alloc_ok ? avail_dec
                                : ctl.finish_free ? avail_inc : avail_reg;
            rsp_reg.used_pages <= ctl.finish_reserve ? used_plus_len
                                : ctl.finish_alloc_ok ? used_inc
                                : ctl.finish_free ? used_dec : used_reg;
        end
    end

    always_comb
    begin
        sts              = '0;
        sts.clr_last     = (ptr_reg == MAP_WORDS_W - 17'd1);
        sts.func_mark    = (func_reg == FUNC_MARK_FREE);
        sts.func_reserve = (func_reg == FUNC_RESERVE);
        sts.func_alloc   = (func_reg == FUNC_ALLOC);
        sts.mark_empty   = (len == '0);
        sts.mark_skip    = (ptr_reg >= MAP_WORDS_W);
        sts.mark_last    = (ptr_reg == end_word) || (ptr_reg + 17'd1 >= MAP_WORDS_W);
        sts.scan_none    = (limit_reg == '0);
        sts.word_hit     = hit_any;
        sts.scan_last    = (ptr_reg + 17'd1 >= limit_reg);
        sts.free_in_map  = (WW'(rb_reg[15:6]) < MAP_WORDS_W);
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

>>> design/bitmap_page_allocator_top.sv
// Bitmap page allocator. Pulse start while busy is low to issue one command;
// the result appears on result for exactly one cycle with done high, and must
// be captured then, since the block cannot be stalled. Reserve and empty
// ranges finish in the decode state; free of a page reads, waits on and
// writes back its bitmap word; mark-free does the same for each bitmap
// word touched; allocate reads, waits on and checks each word scanned up
// to the first word holding a free page, which it writes back. After reset,
// busy stays high while the bitmap is cleared to all-used; words_in_use
// writes are taken at any time.
module bitmap_page_allocator_top
    import bpa_pkg::*;
#(
    parameter int MAP_WORDS = MAP_WORDS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  cmd_t             cmd,
    output logic             done,
    output rsp_t             result,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata
);

    ctl_t ctl;
    sts_t sts;

    bpa_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .busy  (busy),
        .ctl   (ctl)
    );

    bpa_dp #(.MAP_WORDS(MAP_WORDS)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .cmd       (cmd),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .sts       (sts),
        .done      (done),
        .rsp       (result)
    );

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps

module tb;
    import bpa_pkg::*;

    typedef struct {
        func_t  f;
        int     rb;
        int     re;
        bit     typed;
        rsp_t   exp;
    } dir_row_t;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    cmd_t             cmd;
    logic             done;
    rsp_t             result;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_wdata;

    logic [WORD_BITS-1:0] page_map [MAP_WORDS_DEF];
    logic [CNT_W-1:0]     avail_cnt;
    logic [CNT_W-1:0]     used_cnt;
    logic [CFG_W-1:0]     scan_words;

    rsp_t     rsp_q[$];
    int       mismatches;
    int       gap_max;
    dir_row_t dir_rows[15];

    bitmap_page_allocator_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic logic [CNT_W-1:0] sat_add(logic [CNT_W-1:0] a, int unsigned b);
        int unsigned s;
        s = a + b;
        return (s > COUNT_MAX) ? COUNT_MAX : s[CNT_W-1:0];
    endfunction

    function automatic logic [CNT_W-1:0] sat_dec(logic [CNT_W-1:0] a);
        return (a == 0) ? '0 : a - 1'b1;
    endfunction

    function automatic void mark_page(int unsigned pg);
        if (pg / WORD_BITS < MAP_WORDS_DEF)
            page_map[pg / WORD_BITS][pg % WORD_BITS] = 1'b1;
    endfunction

    function automatic rsp_t apply_command(cmd_t c);
        rsp_t        r;
        int unsigned rb;
        int unsigned re;
        int unsigned len;
        int unsigned lim;
        bit          found;
        r = '0;
        rb = c.range_begin;
        re = c.range_end;
        len = (re > rb) ? re - rb : 0;
        found = 1'b0;
        case (func_t'(c.func))
            FUNC_MARK_FREE:
            begin
                for (int unsigned p = rb; p < re; p++)
                    mark_page(p);
                avail_cnt = sat_add(avail_cnt, len);
            end
            FUNC_RESERVE:
                used_cnt = sat_add(used_cnt, len);
            FUNC_ALLOC:
            begin
                lim = (scan_words > MAP_WORDS_DEF) ? MAP_WORDS_DEF : scan_words;
                for (int unsigned w = 0; w < lim && !found; w++)
                    for (int b = 0; b < WORD_BITS && !found; b++)
                        if (page_map[w][b])
                        begin
                            page_map[w][b] = 1'b0;
                            r.page = 16'(w * WORD_BITS + b);
                            found = 1'b1;
                        end
                if (found)
                begin
                    avail_cnt = sat_dec(avail_cnt);
                    used_cnt = sat_add(used_cnt, 1);
                end
                else
                    r.status = 1'b1;
            end
            default:
            begin
                mark_page(rb);
                used_cnt = sat_dec(used_cnt);
                avail_cnt = sat_add(avail_cnt, 1);
            end
        endcase
        r.free_pages = avail_cnt;
        r.used_pages = used_cnt;
        return r;
    endfunction

    task automatic issue(cmd_t c, bit typed, rsp_t exp);
        rsp_t pred;
        repeat ($urandom_range(0, gap_max)) @(posedge clk);
        @(posedge clk);
        start <= 1'b1;
        cmd <= c;
        do @(posedge clk); while (busy);
        start <= 1'b0;
        cmd <= cmd_t'($urandom);
        pred = apply_command(c);
        rsp_q.push_back(typed ? exp : pred);
    endtask

    task automatic write_words(logic [CFG_W-1:0] v);
        while (rsp_q.size() != 0) @(posedge clk);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        scan_words = v;
    endtask

    function automatic cmd_t random_command();
        cmd_t        c;
        int unsigned sel;
        int unsigned rb;
        int unsigned re;
        sel = $urandom_range(0, 99);
        c.range_end = RANGE_W'($urandom);
        rb = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                          : $urandom_range(0, 4095);
        c.range_begin = 16'(rb);
        if (sel < 30)
        begin
            c.func = FUNC_MARK_FREE;
            re = rb + $urandom_range(0, 200);
            if ($urandom_range(0, 40) == 0)
                re = 65536;
            else if ($urandom_range(0, 15) == 0)
                re = $urandom_range(0, rb);
            c.range_end = RANGE_W'((re > 65536) ? 65536 : re);
        end
        else if (sel < 40)
        begin
            c.func = FUNC_RESERVE;
            re = rb + $urandom_range(0, 3000);
            c.range_end = RANGE_W'((re > 65536) ? 65536 : re);
            if ($urandom_range(0, 10) == 0)
                c.range_end = RANGE_W'($urandom);
        end
        else if (sel < 80)
            c.func = FUNC_ALLOC;
        else
            c.func = FUNC_FREE;
        return c;
    endfunction

    always @(posedge clk)
    begin
        rsp_t exp;
        if (rst_n && done)
        begin
            if (rsp_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat %p", result);
            end
            else
            begin
                exp = rsp_q.pop_front();
                if (result.status !== exp.status || result.page !== exp.page ||
                    result.free_pages !== exp.free_pages ||
                    result.used_pages !== exp.used_pages)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("expected %p got %p", exp, result);
                end
            end
        end
    end

    initial
    begin
        #300ms;
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        cmd_t         c;
        logic [CFG_W-1:0] phase_words [6];
        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        mismatches = 0;
        gap_max = 16;
        for (int i = 0; i < MAP_WORDS_DEF; i++)
            page_map[i] = '0;
        avail_cnt = '0;
        used_cnt = '0;
        scan_words = WORDS_RESET;

        dir_rows[0]  = '{FUNC_ALLOC,     0,     0,     1, '{1'b1, 16'd0, 17'd0, 17'd0}};
        dir_rows[1]  = '{FUNC_RESERVE,   10,    5,     1, '{1'b0, 16'd0, 17'd0, 17'd0}};
        dir_rows[2]  = '{FUNC_MARK_FREE, 7,     7,     1, '{1'b0, 16'd0, 17'd0, 17'd0}};
        dir_rows[3]  = '{FUNC_MARK_FREE, 0,     1,     1, '{1'b0, 16'd0, 17'd1, 17'd0}};
        dir_rows[4]  = '{FUNC_ALLOC,     0,     0,     1, '{1'b0, 16'd0, 17'd0, 17'd1}};
        dir_rows[5]  = '{FUNC_ALLOC,     0,     0,     1, '{1'b1, 16'd0, 17'd0, 17'd1}};
        dir_rows[6]  = '{FUNC_FREE,      65535, 0,     1, '{1'b0, 16'd0, 17'd1, 17'd0}};
        dir_rows[7]  = '{FUNC_ALLOC,     0,     0,     1, '{1'b0, 16'hFFFF, 17'd0, 17'd1}};
        dir_rows[8]  = '{FUNC_RESERVE,   0,     65536, 1, '{1'b0, 16'd0, 17'd0, COUNT_MAX}};
        dir_rows[9]  = '{FUNC_MARK_FREE, 65472, 65536, 0, '0};
        dir_rows[10] = '{FUNC_FREE,      65535, 0,     0, '0};
        dir_rows[11] = '{FUNC_MARK_FREE, 0,     65536, 0, '0};
        dir_rows[12] = '{FUNC_ALLOC,     0,     0,     0, '0};
        dir_rows[13] = '{FUNC_FREE,      0,     0,     0, '0};
        dir_rows[14] = '{FUNC_MARK_FREE, 100,   3,     0, '0};

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
        begin
            c.func = dir_rows[i].f;
            c.range_begin = 16'(dir_rows[i].rb);
            c.range_end = RANGE_W'(dir_rows[i].re);
            issue(c, dir_rows[i].typed, dir_rows[i].exp);
        end

        phase_words[0] = 11'd0;
        phase_words[1] = 11'd2047;
        phase_words[2] = 11'd1;
        phase_words[3] = CFG_W'($urandom_range(1, 1024));
        phase_words[4] = CFG_W'($urandom_range(1, 64));
        phase_words[5] = 11'd1024;
        for (int ph = 0; ph < 6; ph++)
        begin
            write_words(phase_words[ph]);
            gap_max = (ph == 2) ? 0 : 16;
            for (int n = 0; n < 225; n++)
                issue(random_command(), 1'b0, '0);
        end

        while (rsp_q.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
